// ===== sv/gmds_pkg.sv =====
// shared types and constants for the grid maze depth-first solver
// no dependencies; imported by gmds_ctrl, gmds_dp and grid_maze_dfs_solver
`default_nettype none

package gmds_pkg;

    localparam int ROWS_MAX = 8;
    localparam int COLS_MAX = 8;
    localparam int ROW_W    = $clog2(ROWS_MAX);
    localparam int COL_W    = $clog2(COLS_MAX);
    localparam int CELLS    = ROWS_MAX * COLS_MAX;
    localparam int CELL_W   = ROW_W + COL_W;
    localparam int DEPTH_W  = CELL_W;
    localparam int SIZE_W   = 4;
    localparam int DIR_W    = 2;
    localparam int TRY_W    = 3;

    localparam logic [TRY_W-1:0] TRY_DONE = 3'd4;

    typedef enum logic [DIR_W-1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [0:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load_cell;
        logic rd_start;
        logic rd_goal;
        logic search_init;
        logic try_step;
        logic pop_req;
        logic pop_apply;
        logic probe;
        logic emit_init;
        logic emit_rd;
        logic emit_next;
        logic res_set;
        logic res_solved;
    } gmds_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_cell;
        logic both_open;
        logic start_is_goal;
        logic try_done;
        logic depth_zero;
        logic nb_valid;
        logic probe_ok;
        logic probe_goal;
        logic emit_last;
    } gmds_status_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        begin
            res = v;
            if (v == '0)
            begin
                res = {{(SIZE_W-1){1'b0}}, 1'b1};
            end
            else if (v > maxv)
            begin
                res = maxv;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/gmds_ctrl.sv =====
// sequencing state machine for the maze solver: load, check, search, emit
// depends on gmds_pkg; drives command struct into gmds_dp
`default_nettype none

module gmds_ctrl
    import gmds_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire gmds_status_t status,
    output gmds_cmd_t         cmd
);

    typedef enum logic [9:0] {
        ST_LOAD      = 10'b0000000001,
        ST_CHK_START = 10'b0000000010,
        ST_CHK_GOAL  = 10'b0000000100,
        ST_CHK_EVAL  = 10'b0000001000,
        ST_TRY       = 10'b0000010000,
        ST_PROBE     = 10'b0000100000,
        ST_POP       = 10'b0001000000,
        ST_EMIT_RD   = 10'b0010000000,
        ST_EMIT_OUT  = 10'b0100000000,
        ST_RESULT    = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT_OUT) || (state_reg == ST_RESULT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_cell = in_valid;
                if (in_valid && status.last_cell)
                begin
                    state_next = ST_CHK_START;
                end
            end
            ST_CHK_START:
            begin
                cmd.rd_start = 1'b1;
                state_next   = ST_CHK_GOAL;
            end
            ST_CHK_GOAL:
            begin
                cmd.rd_goal = 1'b1;
                state_next  = ST_CHK_EVAL;
            end
            ST_CHK_EVAL:
            begin
                if (!status.both_open)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_RESULT;
                end
                else if (status.start_is_goal)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_solved = 1'b1;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_TRY;
                end
            end
            ST_TRY:
            begin
                if (!status.try_done)
                begin
                    cmd.try_step = 1'b1;
                    if (status.nb_valid)
                    begin
                        state_next = ST_PROBE;
                    end
                end
                else if (status.depth_zero)
                begin
                    // every branch from the start exhausted
                    cmd.res_set = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    cmd.pop_req = 1'b1;
                    state_next  = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.pop_apply = 1'b1;
                state_next    = ST_TRY;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.probe_ok && status.probe_goal)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_TRY;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (!out_stall)
                begin
                    if (status.emit_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // loading and answering never overlap
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // the final path step hands control back to loading
    a_last_step_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_OUT) && !out_stall && status.emit_last |=> !in_stall)
        else $error("no return to loading after final step");

    // a search always begins from a checked start and goal
    a_init_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_init |-> ($past(cmd.rd_goal) && status.both_open))
        else $error("search started without start and goal check");

endmodule

`default_nettype wire

// ===== sv/gmds_dp.sv =====
// datapath for the maze solver: config, cell store, visited marks, step stack
// depends on gmds_pkg; commanded by gmds_ctrl
`default_nettype none

module gmds_dp
    import gmds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [SIZE_W-1:0] cfg_data,
    input  wire logic              cell_open,
    input  wire gmds_cmd_t         cmd,
    output gmds_status_t           status,
    output logic [DIR_W-1:0]       direction,
    output logic                   has_step,
    output logic                   solved,
    output logic                   last_step
);

    localparam logic [SIZE_W-1:0] ROWS_MAX_V = SIZE_W'(ROWS_MAX);
    localparam logic [SIZE_W-1:0] COLS_MAX_V = SIZE_W'(COLS_MAX);
    localparam logic [SIZE_W-1:0] SIZE_ONE   = SIZE_W'(1);

    // configuration and load cursor
    logic [SIZE_W-1:0]  rows_reg;
    logic [SIZE_W-1:0]  cols_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;

    // search position
    logic [ROW_W-1:0]   pos_row_reg;
    logic [COL_W-1:0]   pos_col_reg;
    logic [TRY_W-1:0]   try_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] emit_idx_reg;
    logic [ROW_W-1:0]   nb_row_reg;
    logic [COL_W-1:0]   nb_col_reg;
    dir_t               nb_dir_reg;
    logic               start_open_reg;
    logic               step_mode_reg;
    logic               res_solved_reg;

    // memories
    logic               open_mem [CELLS];
    logic               open_rd_reg;
    logic               visited_mem [CELLS];
    logic               visited_rd_reg;
    dir_t               stack_mem [CELLS];
    dir_t               stack_rd_reg;

    logic [SIZE_W-1:0]  rows_m1;
    logic [SIZE_W-1:0]  cols_m1;
    logic [ROW_W-1:0]   goal_row;
    logic [COL_W-1:0]   goal_col;
    logic               col_wrap;
    logic [ROW_W-1:0]   nb_row;
    logic [COL_W-1:0]   nb_col;
    logic               nb_valid;
    logic               open_rd_en;
    logic [CELL_W-1:0]  open_rd_addr;
    logic               visited_wr_en;
    logic [CELL_W-1:0]  visited_wr_addr;
    logic               visited_wr_data;
    logic               stack_rd_en;
    logic [DEPTH_W-1:0] stack_rd_addr;
    logic               probe_ok;

    assign rows_m1  = rows_reg - SIZE_ONE;
    assign cols_m1  = cols_reg - SIZE_ONE;
    assign goal_row = rows_m1[ROW_W-1:0];
    assign goal_col = cols_m1[COL_W-1:0];
    assign col_wrap = (cur_col_reg == goal_col);

    // config registers and load cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= ROWS_MAX_V;
            cols_reg    <= COLS_MAX_V;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ROWS)
            begin
                rows_reg <= clamp_size(cfg_data, ROWS_MAX_V);
            end
            else
            begin
                cols_reg <= clamp_size(cfg_data, COLS_MAX_V);
            end
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else if (cmd.load_cell)
        begin
            if (status.last_cell)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (col_wrap)
            begin
                cur_col_reg <= '0;
                cur_row_reg <= cur_row_reg + ROW_W'(1);
            end
            else
            begin
                cur_col_reg <= cur_col_reg + COL_W'(1);
            end
        end
    end

    // neighbor for the current try direction
    always_comb
    begin
        nb_row   = pos_row_reg;
        nb_col   = pos_col_reg;
        nb_valid = 1'b0;
        case (dir_t'(try_reg[DIR_W-1:0]))
            DIR_UP:
            begin
                nb_row   = pos_row_reg - ROW_W'(1);
                nb_valid = (pos_row_reg != '0);
            end
            DIR_DOWN:
            begin
                nb_row   = pos_row_reg + ROW_W'(1);
                nb_valid = (({1'b0, pos_row_reg} + SIZE_ONE) < rows_reg);
            end
            DIR_LEFT:
            begin
                nb_col   = pos_col_reg - COL_W'(1);
                nb_valid = (pos_col_reg != '0);
            end
            DIR_RIGHT:
            begin
                nb_col   = pos_col_reg + COL_W'(1);
                nb_valid = (({1'b0, pos_col_reg} + SIZE_ONE) < cols_reg);
            end
            default:
            begin
                nb_valid = 1'b0;
            end
        endcase
    end

    // cell store read port
    always_comb
    begin
        open_rd_en   = cmd.rd_start | cmd.rd_goal | cmd.try_step;
        open_rd_addr = {nb_row, nb_col};
        if (cmd.rd_start)
        begin
            open_rd_addr = '0;
        end
        else if (cmd.rd_goal)
        begin
            open_rd_addr = {goal_row, goal_col};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cell)
        begin
            open_mem[{cur_row_reg, cur_col_reg}] <= cell_open;
        end
        if (open_rd_en)
        begin
            open_rd_reg <= open_mem[open_rd_addr];
        end
    end

    // visited marks: cleared as each cell loads, set at the start cell and on each push
    always_comb
    begin
        visited_wr_en   = cmd.load_cell | cmd.search_init | (cmd.probe & probe_ok);
        visited_wr_addr = {nb_row_reg, nb_col_reg};
        visited_wr_data = 1'b1;
        if (cmd.load_cell)
        begin
            visited_wr_addr = {cur_row_reg, cur_col_reg};
            visited_wr_data = 1'b0;
        end
        else if (cmd.search_init)
        begin
            visited_wr_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (visited_wr_en)
        begin
            visited_mem[visited_wr_addr] <= visited_wr_data;
        end
        if (cmd.try_step)
        begin
            visited_rd_reg <= visited_mem[{nb_row, nb_col}];
        end
    end

    // step stack read port: backtrack pop or path emission
    assign stack_rd_en   = cmd.pop_req | cmd.emit_rd;
    assign stack_rd_addr = cmd.pop_req ? (depth_reg - DEPTH_W'(1)) : emit_idx_reg;
    assign probe_ok      = open_rd_reg && !visited_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.probe && probe_ok)
        begin
            stack_mem[depth_reg] <= nb_dir_reg;
        end
        if (stack_rd_en)
        begin
            stack_rd_reg <= stack_mem[stack_rd_addr];
        end
    end

    // search registers
    always_ff @(posedge clk)
    begin
        if (cmd.rd_goal)
        begin
            start_open_reg <= open_rd_reg;
        end

        if (cmd.search_init)
        begin
            pos_row_reg <= '0;
            pos_col_reg <= '0;
            try_reg     <= '0;
            depth_reg   <= '0;
        end
        else if (cmd.try_step)
        begin
            try_reg    <= try_reg + TRY_W'(1);
            nb_row_reg <= nb_row;
            nb_col_reg <= nb_col;
            nb_dir_reg <= dir_t'(try_reg[DIR_W-1:0]);
        end
        else if (cmd.pop_req)
        begin
            depth_reg <= depth_reg - DEPTH_W'(1);
        end
        else if (cmd.pop_apply)
        begin
            // undo the step that led here and resume after it
            case (stack_rd_reg)
                DIR_UP:    pos_row_reg <= pos_row_reg + ROW_W'(1);
                DIR_DOWN:  pos_row_reg <= pos_row_reg - ROW_W'(1);
                DIR_LEFT:  pos_col_reg <= pos_col_reg + COL_W'(1);
                DIR_RIGHT: pos_col_reg <= pos_col_reg - COL_W'(1);
                default:   pos_row_reg <= pos_row_reg;
            endcase
            try_reg <= {1'b0, stack_rd_reg} + TRY_W'(1);
        end
        else if (cmd.probe && probe_ok)
        begin
            depth_reg   <= depth_reg + DEPTH_W'(1);
            pos_row_reg <= nb_row_reg;
            pos_col_reg <= nb_col_reg;
            try_reg     <= '0;
        end

        if (cmd.emit_init)
        begin
            emit_idx_reg  <= '0;
            step_mode_reg <= 1'b1;
        end
        else if (cmd.emit_next)
        begin
            emit_idx_reg <= emit_idx_reg + DEPTH_W'(1);
        end

        if (cmd.res_set)
        begin
            step_mode_reg  <= 1'b0;
            res_solved_reg <= cmd.res_solved;
        end
    end

    always_comb
    begin
        status.last_cell     = col_wrap && (cur_row_reg == goal_row);
        status.both_open     = start_open_reg && open_rd_reg;
        status.start_is_goal = (goal_row == '0) && (goal_col == '0);
        status.try_done      = (try_reg == TRY_DONE);
        status.depth_zero    = (depth_reg == '0);
        status.nb_valid      = nb_valid;
        status.probe_ok      = probe_ok;
        status.probe_goal    = (nb_row_reg == goal_row) && (nb_col_reg == goal_col);
        status.emit_last     = (emit_idx_reg == (depth_reg - DEPTH_W'(1)));
    end

    assign direction = step_mode_reg ? stack_rd_reg : DIR_UP;
    assign has_step  = step_mode_reg;
    assign solved    = step_mode_reg | res_solved_reg;
    assign last_step = step_mode_reg ? status.emit_last : 1'b1;

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe && probe_ok |=> depth_reg == $past(depth_reg) + DEPTH_W'(1))
        else $error("stack depth did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_req |=> depth_reg == $past(depth_reg) - DEPTH_W'(1))
        else $error("stack depth did not shrink on pop");

    a_try_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.try_step |-> (try_reg != TRY_DONE) && !cmd.pop_req)
        else $error("direction tried after all four were used");

endmodule

`default_nettype wire

// ===== sv/grid_maze_dfs_solver.sv =====
// top level of the grid maze depth-first solver
// depends on gmds_pkg, gmds_ctrl and gmds_dp
//
//  channel  | strobe    | hold       | payload
//  ---------+-----------+------------+----------------------------------------
//  cfg      | cfg_write | (none)     | cfg_index, cfg_data
//  in       | in_valid  | in_stall   | cell_open
//  out      | out_valid | out_stall  | direction, has_step, solved, last_step
//
// cells load one per cycle while not stalled; after the last cell, start and goal
// are read, then checked; the search tries directions in ST_TRY, probes in-grid
// neighbors in ST_PROBE and backtracks via ST_POP; each path step is one stack
// read; visited marks sit in a memory cleared cell by cell as the maze loads
// input is stalled from the last cell until the last result transaction
// async active-low reset restores 8x8 size and an empty load cursor
`default_nettype none

module grid_maze_dfs_solver
    import gmds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [SIZE_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cell_open,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DIR_W-1:0]       direction,
    output logic                   has_step,
    output logic                   solved,
    output logic                   last_step
);

    gmds_cmd_t    cmd;
    gmds_status_t status;

    gmds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gmds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_open (cell_open),
        .cmd       (cmd),
        .status    (status),
        .direction (direction),
        .has_step  (has_step),
        .solved    (solved),
        .last_step (last_step)
    );

endmodule

`default_nettype wire

// ===== verif/grid_maze_dfs_solver_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for grid_maze_dfs_solver: directed and random mazes
// depends on gmds_pkg and the solver rtl; expected paths come from a local depth-first search

module grid_maze_dfs_solver_tb
    import gmds_pkg::*;
();

    typedef struct packed {
        dir_t direction;
        logic has_step;
        logic solved;
        logic last_step;
    } step_t;

    // row-major: a snake to the right, down, back to the left, down again and right to the goal
    localparam logic [0:14] SNAKE_MAZE = 15'b111_001_111_100_111;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              cell_open;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DIR_W-1:0]  direction;
    logic              has_step;
    logic              solved;
    logic              last_step;

    // local copy of the maze, load cursor and size
    logic [CELLS-1:0] maze_cells;
    int               loaded;
    int               cur_row;
    int               cur_col;
    int               maze_rows;
    int               maze_cols;

    step_t            due_steps[$];
    step_t            want;
    int               errors;
    int               results_checked;
    int               cells_sent;
    int               mazes_done;
    int               idle_pct;
    int               stall_pct;

    grid_maze_dfs_solver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_open (cell_open),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .direction (direction),
        .has_step  (has_step),
        .solved    (solved),
        .last_step (last_step)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("grid_maze_dfs_solver_tb failed");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int fit_size(input logic [SIZE_W-1:0] v, input int limit);
        begin
            if (v == '0)
            begin
                return 1;
            end
            if (int'(v) > limit)
            begin
                return limit;
            end
            return int'(v);
        end
    endfunction

    // append one expected result transaction
    function automatic void queue_answer(input step_t s);
        begin
            due_steps.insert(due_steps.size(), s);
        end
    endfunction

    // depth-first search, neighbors up/down/left/right; queues the answer
    function automatic void solve_maze();
        bit [CELLS-1:0] seen;
        dir_t           path[CELLS];
        int             tries[CELLS];
        int             r;
        int             c;
        int             nr;
        int             nc;
        int             depth;
        int             goal_r;
        int             goal_c;
        bit             found;
        bit             searching;
        begin
            seen   = '0;
            r      = 0;
            c      = 0;
            depth  = 0;
            found  = 1'b0;
            goal_r = maze_rows - 1;
            goal_c = maze_cols - 1;
            if (maze_cells[0] && maze_cells[goal_r * COLS_MAX + goal_c])
            begin
                seen[0] = 1'b1;
                if (goal_r == 0 && goal_c == 0)
                begin
                    found = 1'b1;
                end
                else
                begin
                    tries[0]  = 0;
                    searching = 1'b1;
                    while (searching)
                    begin
                        if (tries[depth] >= 4)
                        begin
                            if (depth == 0)
                            begin
                                searching = 1'b0;
                            end
                            else
                            begin
                                depth--;
                                case (path[depth])
                                    DIR_UP:    r++;
                                    DIR_DOWN:  r--;
                                    DIR_LEFT:  c++;
                                    default:   c--;
                                endcase
                            end
                        end
                        else
                        begin
                            nr = r;
                            nc = c;
                            case (dir_t'(tries[depth]))
                                DIR_UP:    nr = r - 1;
                                DIR_DOWN:  nr = r + 1;
                                DIR_LEFT:  nc = c - 1;
                                default:   nc = c + 1;
                            endcase
                            path[depth] = dir_t'(tries[depth]);
                            tries[depth]++;
                            if (nr >= 0 && nr < maze_rows && nc >= 0 && nc < maze_cols
                                && maze_cells[nr * COLS_MAX + nc]
                                && !seen[nr * COLS_MAX + nc])
                            begin
                                depth++;
                                r = nr;
                                c = nc;
                                seen[r * COLS_MAX + c] = 1'b1;
                                if (r == goal_r && c == goal_c)
                                begin
                                    found     = 1'b1;
                                    searching = 1'b0;
                                end
                                else
                                begin
                                    tries[depth] = 0;
                                end
                            end
                        end
                    end
                end
            end
            if (!found)
            begin
                queue_answer('{DIR_UP, 1'b0, 1'b0, 1'b1});
            end
            else if (depth == 0)
            begin
                queue_answer('{DIR_UP, 1'b0, 1'b1, 1'b1});
            end
            else
            begin
                for (int k = 0; k < depth; k++)
                begin
                    queue_answer('{path[k], 1'b1, 1'b1, k == depth - 1});
                end
            end
        end
    endfunction

    function automatic void take_cell(input logic open_bit);
        begin
            maze_cells[cur_row * COLS_MAX + cur_col] = open_bit;
            loaded++;
            cur_col++;
            if (cur_col >= maze_cols)
            begin
                cur_col = 0;
                cur_row++;
            end
            if (loaded >= maze_rows * maze_cols)
            begin
                loaded  = 0;
                cur_row = 0;
                cur_col = 0;
                mazes_done++;
                solve_maze();
            end
        end
    endfunction

    // called at a falling edge with the input channel idle
    task automatic write_reg(input cfg_idx_t idx, input logic [SIZE_W-1:0] val);
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(negedge clk);
            cfg_write <= 1'b0;
            if (idx == CFG_ROWS)
            begin
                maze_rows = fit_size(val, ROWS_MAX);
            end
            else
            begin
                maze_cols = fit_size(val, COLS_MAX);
            end
            // any size write restarts the load cursor
            loaded  = 0;
            cur_row = 0;
            cur_col = 0;
        end
    endtask

    task automatic send_cell(input logic open_bit);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            cell_open <= open_bit;
            do
                @(posedge clk);
            while (in_stall);
            cells_sent++;
            take_cell(open_bit);
            @(negedge clk);
        end
    endtask

    // hold off input until every queued answer is back, then let the block settle
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (due_steps.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (8) @(negedge clk);
        end
    endtask

    task automatic check_field(input string field, input logic [1:0] exp_v,
                               input logic [1:0] got_v);
        begin
            if (got_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, exp_v, got_v);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_steps.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with none expected: %s %0d %0b %0b %0b",
                         $time, "dir/step/ok/last", direction, has_step, solved,
                         last_step);
            end
            else
            begin
                want = due_steps.pop_front();
                results_checked++;
                check_field("direction", want.direction, direction);
                check_field("has_step", 2'(want.has_step), 2'(has_step));
                check_field("solved", 2'(want.solved), 2'(solved));
                check_field("last_step", 2'(want.last_step), 2'(last_step));
            end
        end
    end

    function automatic logic [SIZE_W-1:0] pick_size();
        int choice;
        begin
            choice = $urandom_range(9);
            if (choice == 0)
            begin
                return '0;
            end
            if (choice == 1)
            begin
                return SIZE_W'($urandom_range(15, 8));
            end
            return SIZE_W'($urandom_range(4, 1));
        end
    endfunction

    // single-cell mazes: start equals goal, and a walled start; size 0 clamps to 1
    task automatic test_trivial_mazes();
        begin
            write_reg(CFG_ROWS, 4'd0);
            write_reg(CFG_COLS, 4'd1);
            send_cell(1'b1);
            send_cell(1'b0);
        end
    endtask

    task automatic test_blocked_ends();
        begin
            wait_idle();
            write_reg(CFG_COLS, 4'd2);
            send_cell(1'b0);
            send_cell(1'b1);
            send_cell(1'b1);
            send_cell(1'b0);
        end
    endtask

    // path with right, down and left steps
    task automatic test_snake_path();
        begin
            wait_idle();
            write_reg(CFG_ROWS, 4'd5);
            write_reg(CFG_COLS, 4'd3);
            for (int k = 0; k < 15; k++)
            begin
                send_cell(SNAKE_MAZE[k]);
            end
        end
    endtask

    // a size write in the middle of a load drops the cells already taken
    task automatic test_reload_on_write();
        begin
            wait_idle();
            write_reg(CFG_ROWS, 4'd2);
            write_reg(CFG_COLS, 4'd2);
            send_cell(1'b0);
            send_cell(1'b0);
            wait_idle();
            write_reg(CFG_ROWS, 4'd1);
            send_cell(1'b1);
            send_cell(1'b1);
        end
    endtask

    task automatic test_random_mazes(input int gap_pct, input int hold_pct,
                                     input int cell_budget, input bit full_grid);
        int  sent;
        int  got_before;
        int  density;
        bit  first;
        begin
            idle_pct   = gap_pct;
            stall_pct  = hold_pct;
            sent       = 0;
            got_before = results_checked;
            first      = 1'b1;
            while (sent < cell_budget || results_checked - got_before < 6)
            begin
                if (first || $urandom_range(1) == 1)
                begin
                    wait_idle();
                    if (first && full_grid)
                    begin
                        write_reg(CFG_ROWS, 4'd15);
                        write_reg(CFG_COLS, 4'd8);
                    end
                    else
                    begin
                        write_reg(CFG_ROWS, pick_size());
                        write_reg(CFG_COLS, pick_size());
                    end
                    first = 1'b0;
                end
                // mostly open mazes so the search runs deep; some sparse ones
                density = ($urandom_range(9) == 0) ? 50 : 85;
                for (int k = 0; k < maze_rows * maze_cols; k++)
                begin
                    send_cell($urandom_range(99) < density);
                end
                sent += maze_rows * maze_cols;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_ROWS;
        cfg_data        = '0;
        in_valid        = 1'b0;
        cell_open       = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        errors          = 0;
        results_checked = 0;
        cells_sent      = 0;
        mazes_done      = 0;
        maze_cells      = '0;
        maze_rows       = ROWS_MAX;
        maze_cols       = COLS_MAX;
        loaded          = 0;
        cur_row         = 0;
        cur_col         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_trivial_mazes();
        test_blocked_ends();
        test_snake_path();
        test_reload_on_write();
        test_random_mazes(0, 0, 8, 1'b0);
        test_random_mazes(49, 0, 8, 1'b0);
        test_random_mazes(0, 49, 8, 1'b0);
        test_random_mazes(18, 18, 0, 1'b1);

        wait_idle();
        repeat (20) @(negedge clk);
        $display("covered %0d mazes from %0d cell transactions, %0d result transactions checked",
                 mazes_done, cells_sent, results_checked);
        $display("sizes 1x1 to 8x8 with clamped writes, dead ends, walled start and goal, reload");
        if (errors == 0)
        begin
            $display("grid_maze_dfs_solver_tb passed");
        end
        else
        begin
            $display("grid_maze_dfs_solver_tb failed");
        end
        $finish;
    end

endmodule

// ===== grid_maze_dfs_solver.f =====
sv/gmds_pkg.sv
sv/gmds_ctrl.sv
sv/gmds_dp.sv
sv/grid_maze_dfs_solver.sv
verif/grid_maze_dfs_solver_tb.sv
